FILE: rtl/bdar_pkg.sv
// Shared types and constants for the button debounce and auto-repeat unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdar_pkg;

	// Fixed field widths of the ports.
	localparam int IDX_W     = 3;
	localparam int REG_W     = 24;
	localparam int OUT_W     = 24;
	localparam int CFG_IDX_W = 1;

	// Defaults for the top-level parameters.
	localparam int NUM_BUTTONS_DEF = 5;
	localparam int COUNT_WIDTH_DEF = 24;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 1'd1;
	localparam logic [REG_W-1:0]     DEBOUNCE_RESET = 24'd20000;
	localparam logic [REG_W-1:0]     REPEAT_RESET   = 24'd460000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP1,
		ST_STEP2,
		ST_DIVIDE,
		ST_ADVANCE,
		ST_FINISH
	} bdar_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step1;
		logic step2;
		logic advance;
		logic finish;
	} bdar_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic div_busy;
		logic out_blocked;
	} bdar_status_t;

endpackage

`default_nettype wire

FILE: rtl/button_debounce_accel_repeat_unit.sv
// Top level of the button debounce unit with accelerating auto-repeat.
// Joins bdar_ctrl and bdar_datapath; types and constants from bdar_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is one poll sample for one button and yields exactly
// one result transaction. An accepted sample passes through the states STEP1
// and STEP2, and its result is written to the output register in FINISH; when a
// repeat falls due, DIVIDE and ADVANCE come between: the repeat mark then
// advances by repeat_ticks divided by the repeat count, which a restoring
// serial divider works out one quotient bit per cycle over the 24 bits of
// repeat_ticks. Samples are handled one at a time: a new sample is not taken
// until the previous result is in the output register, and it is accepted
// then even if that result has not been taken yet. Button indexes at or above
// NUM_BUTTONS leave all state alone and return all-zero results. Configuration
// writes are always ready and must only be issued while the unit is idle.
module button_debounce_accel_repeat_unit #(
	parameter int NUM_BUTTONS = bdar_pkg::NUM_BUTTONS_DEF,
	parameter int COUNT_WIDTH = bdar_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [bdar_pkg::IDX_W-1:0]     button_index,
	input  wire logic                           pin_level,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                pressed,
	output logic                                pressed_before,
	output logic [bdar_pkg::OUT_W-1:0]          repeat_count,
	output logic [bdar_pkg::OUT_W-1:0]          repeat_before,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bdar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bdar_pkg::REG_W-1:0]     cfg_data
);

	bdar_pkg::bdar_cmd_t    cmd;
	bdar_pkg::bdar_status_t status;

	bdar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bdar_datapath #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.button_index   (button_index),
		.pin_level      (pin_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pressed        (pressed),
		.pressed_before (pressed_before),
		.repeat_count   (repeat_count),
		.repeat_before  (repeat_before)
	);

endmodule

`default_nettype wire

FILE: rtl/bdar_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Standalone; used by the datapath of the debounce and auto-repeat unit.
`timescale 1ns / 1ps
`default_nettype none

module bdar_divider #(
	parameter int DIVIDEND_W = 24,
	parameter int DIVISOR_W  = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       busy,
	output logic [DIVIDEND_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The quotient shifts in where the dividend shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/bdar_ctrl.sv
// Controller state machine of the debounce and auto-repeat unit.
// Depends on bdar_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module bdar_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire bdar_pkg::bdar_status_t status,
	output bdar_pkg::bdar_cmd_t        cmd
);

	bdar_pkg::bdar_state_t state_q;
	bdar_pkg::bdar_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdar_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bdar_pkg::ST_IDLE: begin
				if (in_valid) state_next = bdar_pkg::ST_STEP1;
			end
			bdar_pkg::ST_STEP1: begin
				state_next = bdar_pkg::ST_STEP2;
			end
			bdar_pkg::ST_STEP2: begin
				state_next = status.hit ? bdar_pkg::ST_DIVIDE : bdar_pkg::ST_FINISH;
			end
			bdar_pkg::ST_DIVIDE: begin
				if (!status.div_busy) state_next = bdar_pkg::ST_ADVANCE;
			end
			bdar_pkg::ST_ADVANCE: begin
				state_next = bdar_pkg::ST_FINISH;
			end
			bdar_pkg::ST_FINISH: begin
				if (!status.out_blocked) state_next = bdar_pkg::ST_IDLE;
			end
			default: begin
				state_next = bdar_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			bdar_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			bdar_pkg::ST_STEP1: begin
				cmd.step1 = 1'b1;
			end
			bdar_pkg::ST_STEP2: begin
				cmd.step2 = 1'b1;
			end
			bdar_pkg::ST_DIVIDE: begin
			end
			bdar_pkg::ST_ADVANCE: begin
				cmd.advance = 1'b1;
			end
			bdar_pkg::ST_FINISH: begin
				cmd.finish = !status.out_blocked;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/bdar_datapath.sv
// Datapath of the debounce and auto-repeat unit: per-button state, working
// registers, configuration registers and output register. Uses bdar_pkg
// and bdar_divider.
`timescale 1ns / 1ps
`default_nettype none

module bdar_datapath #(
	parameter int NUM_BUTTONS = bdar_pkg::NUM_BUTTONS_DEF,
	parameter int COUNT_WIDTH = bdar_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bdar_pkg::bdar_cmd_t            cmd,
	output bdar_pkg::bdar_status_t              status,
	input  wire logic [bdar_pkg::IDX_W-1:0]     button_index,
	input  wire logic                           pin_level,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bdar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bdar_pkg::REG_W-1:0]     cfg_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                pressed,
	output logic                                pressed_before,
	output logic [bdar_pkg::OUT_W-1:0]          repeat_count,
	output logic [bdar_pkg::OUT_W-1:0]          repeat_before
);

	localparam int CW = COUNT_WIDTH;
	localparam int RW = bdar_pkg::REG_W;
	localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int XW = (IW > bdar_pkg::IDX_W) ? IW : bdar_pkg::IDX_W;
	localparam int EW = (CW > RW) ? CW : RW;

	localparam logic [CW-1:0] CMAX   = {CW{1'b1}};
	localparam logic [EW:0]   CMAX_X = (EW + 1)'(CMAX);

	// Configuration registers.
	logic [RW-1:0] debounce_q;
	logic [RW-1:0] repeat_q;

	// Per-button state, one flip-flop row per button.
	logic          flag_mem_q [NUM_BUTTONS];
	logic [CW-1:0] cnt_mem_q  [NUM_BUTTONS];
	logic [CW-1:0] mark_mem_q [NUM_BUTTONS];
	logic [CW-1:0] rep_mem_q  [NUM_BUTTONS];

	// Working copy of the addressed button for the transaction at hand.
	logic [IW-1:0] idx_q;
	logic          in_range_q;
	logic          held_q;
	logic          counted_q;
	logic          flag_q;
	logic          flag_prior_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] mark_q;
	logic [CW-1:0] rep_q;
	logic [CW-1:0] rep_prior_q;

	// Output register.
	logic              out_valid_q;
	logic              pressed_q;
	logic              pressed_before_q;
	logic [bdar_pkg::OUT_W-1:0] repeat_count_q;
	logic [bdar_pkg::OUT_W-1:0] repeat_before_q;

	logic [XW-1:0] idx_x;
	logic          in_range;
	logic [CW-1:0] cnt_inc;
	logic          press;
	logic [EW:0]   sum_press;
	logic [CW-1:0] mark_press;
	logic [CW-1:0] rep_inc;
	logic          hit;
	logic [EW:0]   sum_adv;
	logic [CW-1:0] mark_adv;
	logic          div_busy;
	logic [RW-1:0] quotient;

	always_comb begin
		idx_x      = XW'(button_index);
		in_range   = 32'(button_index) < NUM_BUTTONS;
		cnt_inc    = cnt_q + 1'b1;
		press      = EW'(cnt_inc) == EW'(debounce_q);
		sum_press  = (EW + 1)'(debounce_q) + (EW + 1)'(repeat_q);
		mark_press = (sum_press > CMAX_X) ? CMAX : sum_press[CW-1:0];
		rep_inc    = (rep_q == CMAX) ? CMAX : rep_q + 1'b1;
		// A repeat fires only on a sample where the counter actually rose.
		hit        = in_range_q && held_q && counted_q && (mark_q != '0) &&
			(cnt_q == mark_q);
		sum_adv    = (EW + 1)'(mark_q) + (EW + 1)'(quotient);
		mark_adv   = (sum_adv > CMAX_X) ? CMAX : sum_adv[CW-1:0];
	end

	bdar_divider #(
		.DIVIDEND_W (RW),
		.DIVISOR_W  (CW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.step2 && hit),
		.dividend (repeat_q),
		.divisor  (rep_inc),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bdar_pkg::DEBOUNCE_RESET;
			repeat_q   <= bdar_pkg::REPEAT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bdar_pkg::REG_DEBOUNCE: debounce_q <= cfg_data;
				bdar_pkg::REG_REPEAT:   repeat_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				flag_mem_q[i] <= 1'b0;
				cnt_mem_q[i]  <= '0;
				mark_mem_q[i] <= '0;
				rep_mem_q[i]  <= '0;
			end
		end else if (cmd.finish && in_range_q) begin
			flag_mem_q[idx_q] <= flag_q;
			cnt_mem_q[idx_q]  <= cnt_q;
			mark_mem_q[idx_q] <= mark_q;
			rep_mem_q[idx_q]  <= rep_q;
		end
	end

	// Working registers: loaded on acceptance, then updated step by step.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q      <= idx_x[IW-1:0];
			in_range_q <= in_range;
			held_q     <= !pin_level;
			counted_q  <= 1'b0;
			if (in_range) begin
				flag_q       <= flag_mem_q[idx_x[IW-1:0]];
				flag_prior_q <= flag_mem_q[idx_x[IW-1:0]];
				cnt_q        <= cnt_mem_q[idx_x[IW-1:0]];
				mark_q       <= mark_mem_q[idx_x[IW-1:0]];
				rep_q        <= rep_mem_q[idx_x[IW-1:0]];
				rep_prior_q  <= rep_mem_q[idx_x[IW-1:0]];
			end else begin
				flag_q       <= 1'b0;
				flag_prior_q <= 1'b0;
				cnt_q        <= '0;
				mark_q       <= '0;
				rep_q        <= '0;
				rep_prior_q  <= '0;
			end
		end else if (cmd.step1) begin
			if (in_range_q) begin
				if (held_q) begin
					if (cnt_q != CMAX) begin
						cnt_q     <= cnt_inc;
						counted_q <= 1'b1;
						if (press) begin
							flag_q <= 1'b1;
							mark_q <= mark_press;
							rep_q  <= rep_inc;
						end
					end
				end else begin
					flag_q      <= 1'b0;
					cnt_q       <= '0;
					mark_q      <= '0;
					rep_q       <= '0;
					rep_prior_q <= '0;
				end
			end
		end else if (cmd.step2) begin
			if (hit) begin
				rep_q <= rep_inc;
			end
		end else if (cmd.advance) begin
			mark_q <= mark_adv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pressed_q        <= flag_q;
			pressed_before_q <= flag_prior_q;
			repeat_count_q   <= bdar_pkg::OUT_W'(rep_q);
			repeat_before_q  <= bdar_pkg::OUT_W'(rep_prior_q);
		end
	end

	always_comb begin
		status.hit         = hit;
		status.div_busy    = div_busy;
		status.out_blocked = out_valid_q && out_stall;
	end

	assign out_valid      = out_valid_q;
	assign pressed        = pressed_q;
	assign pressed_before = pressed_before_q;
	assign repeat_count   = repeat_count_q;
	assign repeat_before  = repeat_before_q;

endmodule

`default_nettype wire

FILE: verif/bdar_checker.sv
// Result checker for button_debounce_accel_repeat_unit: follows the sample, result and
// register channels, predicts every result and compares it field by field.
// Depends on bdar_pkg for field widths, register indexes and reset values.
`timescale 1ns / 1ps

module bdar_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [bdar_pkg::IDX_W-1:0]     button_index,
	input  logic                           pin_level,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           pressed,
	input  logic                           pressed_before,
	input  logic [bdar_pkg::OUT_W-1:0]     repeat_count,
	input  logic [bdar_pkg::OUT_W-1:0]     repeat_before,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bdar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdar_pkg::REG_W-1:0]     cfg_data,
	output int                             pending,
	output int                             fail_count
);

	localparam int NB = bdar_pkg::NUM_BUTTONS_DEF;
	localparam int CW = bdar_pkg::COUNT_WIDTH_DEF;
	localparam int OW = bdar_pkg::OUT_W;
	localparam int RW = bdar_pkg::REG_W;
	localparam int IW = bdar_pkg::IDX_W;
	localparam logic [CW-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic          pressed;
		logic          pressed_before;
		logic [OW-1:0] repeat_count;
		logic [OW-1:0] repeat_before;
	} poll_result_t;

	poll_result_t expected_results[$];

	logic [RW-1:0] deb_ticks;
	logic [RW-1:0] rep_ticks;

	logic          debounced[NB];
	logic          debounced_was[NB];
	logic [CW-1:0] hold_cnt[NB];
	logic [CW-1:0] repeat_mark[NB];
	logic [CW-1:0] rep_cnt[NB];
	logic [CW-1:0] rep_cnt_was[NB];

	function automatic logic [CW-1:0] sat_sum(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? CNT_MAX : s[CW-1:0];
	endfunction

	// Advances one button's debounce state by one poll sample.
	task automatic predict_poll(input logic [IW-1:0] idx, input logic pin,
			output poll_result_t res);
		int k;
		res = '0;
		if (int'(idx) < NB) begin
			k = int'(idx);
			debounced_was[k] = debounced[k];
			rep_cnt_was[k] = rep_cnt[k];
			if (!pin) begin
				// A saturated counter no longer rises, so neither test can fire.
				if (hold_cnt[k] != CNT_MAX) begin
					hold_cnt[k] = hold_cnt[k] + 1'b1;
					if (hold_cnt[k] == deb_ticks) begin
						debounced[k] = 1'b1;
						repeat_mark[k] = sat_sum(deb_ticks, rep_ticks);
						rep_cnt[k] = sat_sum(rep_cnt[k], CW'(1));
					end
					if (repeat_mark[k] != '0 && hold_cnt[k] == repeat_mark[k]) begin
						rep_cnt[k] = sat_sum(rep_cnt[k], CW'(1));
						repeat_mark[k] = sat_sum(repeat_mark[k], rep_ticks / rep_cnt[k]);
					end
				end
			end else begin
				debounced[k] = 1'b0;
				hold_cnt[k] = '0;
				repeat_mark[k] = '0;
				rep_cnt[k] = '0;
				rep_cnt_was[k] = '0;
			end
			res.pressed = debounced[k];
			res.pressed_before = debounced_was[k];
			res.repeat_count = rep_cnt[k][OW-1:0];
			res.repeat_before = rep_cnt_was[k][OW-1:0];
		end
	endtask

	task automatic check_field(input string field, input logic [OW-1:0] want,
			input logic [OW-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		poll_result_t res;
		poll_result_t head;
		if (!arst_n) begin
			expected_results.delete();
			deb_ticks = bdar_pkg::DEBOUNCE_RESET;
			rep_ticks = bdar_pkg::REPEAT_RESET;
			for (int i = 0; i < NB; i++) begin
				debounced[i] = 1'b0;
				debounced_was[i] = 1'b0;
				hold_cnt[i] = '0;
				repeat_mark[i] = '0;
				rep_cnt[i] = '0;
				rep_cnt_was[i] = '0;
			end
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual %b %b %0d %0d",
						$time, pressed, pressed_before, repeat_count, repeat_before);
				end else begin
					head = expected_results.pop_front();
					check_field("pressed", OW'(head.pressed), OW'(pressed));
					check_field("pressed_before", OW'(head.pressed_before),
						OW'(pressed_before));
					check_field("repeat_count", head.repeat_count, repeat_count);
					check_field("repeat_before", head.repeat_before, repeat_before);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bdar_pkg::REG_DEBOUNCE: begin
						deb_ticks = cfg_data;
					end
					bdar_pkg::REG_REPEAT: begin
						rep_ticks = cfg_data;
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_poll(button_index, pin_level, res);
				expected_results.push_back(res);
			end
			pending = expected_results.size();
		end
	end

endmodule

FILE: verif/tb.sv
// Testbench top for button_debounce_accel_repeat_unit: clock, reset, poll and register
// stimulus, result-side stalls and the verdict. Needs bdar_pkg and bdar_checker.
`timescale 1ns / 1ps

module tb;

	localparam int NB = bdar_pkg::NUM_BUTTONS_DEF;
	localparam int IW = bdar_pkg::IDX_W;
	localparam int RW = bdar_pkg::REG_W;
	localparam int OW = bdar_pkg::OUT_W;
	localparam int CIW = bdar_pkg::CFG_IDX_W;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_SAMPLES = 220;
	localparam int NUM_PHASES = 8;
	localparam logic [RW-1:0] REG_MAX = '1;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	logic [IW-1:0]  button_index = '0;
	logic           pin_level = 1'b1;
	logic           out_valid;
	logic           out_stall = 1'b0;
	logic           pressed;
	logic           pressed_before;
	logic [OW-1:0]  repeat_count;
	logic [OW-1:0]  repeat_before;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [CIW-1:0] cfg_index = bdar_pkg::REG_DEBOUNCE;
	logic [RW-1:0]  cfg_data = '0;

	int pending;
	int fail_count;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off_req = 1'b0;

	always #5 clk = ~clk;

	button_debounce_accel_repeat_unit dut (.*);

	bdar_checker checker_i (.*);

	initial begin
		#20_000_000;
		$display("tb failed");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request so the unit fills up.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_sample(input logic [IW-1:0] idx, input logic pin);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		button_index <= idx;
		pin_level <= pin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Sends a poll sample with a random index and a random pin level.
	task automatic send_noise();
		send_sample(IW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
	endtask

	task automatic set_config(input logic [RW-1:0] deb, input logic [RW-1:0] rep);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= bdar_pkg::REG_DEBOUNCE;
		cfg_data <= deb;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_index <= bdar_pkg::REG_REPEAT;
		cfg_data <= rep;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic release_all();
		for (int b = 0; b < NB; b++) begin
			send_sample(IW'(b), 1'b1);
		end
	endtask

	// Mostly whole presses of random length on one button, with polls of other
	// buttons mixed in, some holds left without a release, and some pure noise.
	task automatic random_phase(input int n, input int deb, input int rep);
		int sent;
		int len;
		int lmax;
		int b;
		sent = 0;
		release_all();
		while (sent < n) begin
			if ($urandom_range(0, 99) < 75) begin
				b = $urandom_range(0, NB - 1);
				lmax = deb + 3 * rep + 2;
				if (lmax > 150) begin
					lmax = 150;
				end
				len = $urandom_range(1, lmax);
				repeat (len) begin
					if ($urandom_range(0, 99) < 15) begin
						send_noise();
						sent++;
					end
					send_sample(IW'(b), 1'b0);
					sent++;
				end
				if ($urandom_range(0, 99) < 85) begin
					send_sample(IW'(b), 1'b1);
					sent++;
				end
			end else begin
				send_noise();
				sent++;
			end
		end
	endtask

	initial begin
		int deb;
		int rep;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings, including indexes past the last button with both pin levels.
		send_sample(0, 1'b0);
		send_sample(4, 1'b1);
		send_sample(5, 1'b0);
		send_sample(6, 1'b1);
		send_sample(7, 1'b0);
		send_sample(7, 1'b1);

		// Press on the first held sample; the first repeat after it leaves a zero step.
		set_config(1, 1);
		repeat (4) send_sample(1, 1'b0);
		send_sample(1, 1'b1);
		send_sample(2, 1'b0);

		// The first repeat mark saturates.
		set_config(2, REG_MAX);
		repeat (3) send_sample(3, 1'b0);
		send_sample(3, 1'b1);

		set_config(REG_MAX, 1);
		repeat (2) send_sample(4, 1'b0);
		send_sample(4, 1'b1);

		// A zero debounce setting never lets a button become pressed.
		set_config(0, 5);
		repeat (2) send_sample(2, 1'b0);
		release_all();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			deb = $urandom_range(1, 12);
			rep = $urandom_range(1, 64);
			case (ph)
				0: begin
					deb = 3;
					rep = 20;
				end
				1: begin
					deb = 1;
					rep = 1;
				end
				2: begin
					deb = 4;
					rep = REG_MAX;
				end
				3: begin
					deb = 2;
					rep = 7;
				end
				default: ;
			endcase
			set_config(RW'(deb), RW'(rep));
			send_gap_pct = (ph == 1 || ph == 5) ? 62 : (ph == 4 || ph == 7) ? 23 : 0;
			recv_stall_pct = (ph == 3 || ph == 6) ? 62 : (ph == 4 || ph == 7) ? 23 : 0;
			if (ph == 2) begin
				hold_off_req = 1'b1;
			end
			random_phase(PHASE_SAMPLES, deb, rep);
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/bdar_pkg.sv
rtl/bdar_divider.sv
rtl/bdar_ctrl.sv
rtl/bdar_datapath.sv
rtl/button_debounce_accel_repeat_unit.sv
verif/bdar_checker.sv
verif/tb.sv
